// ----- sv/asps_pkg.sv -----
package asps_pkg;

    localparam int SLOT_COUNT_DEF   = 16;
    localparam int PACKET_BYTES_DEF = 32;
    localparam int WINDOW_COUNT_DEF = 16;
    localparam int PAYLOAD_MAX_DEF  = 15;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_SETTINGS = 2'd0,
        CMD_PAYLOAD  = 2'd1,
        CMD_TRANSMIT = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot_number;
        logic [15:0] window_mask;
        logic [3:0]  payload_length;
        logic [3:0]  byte_offset;
        logic [7:0]  byte_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
        logic       empty_packet;
    } t_out_word;

    // Request from the sequencer to the slot store for one access.
    typedef struct packed {
        logic        slot_we;
        logic [3:0]  slot_addr;
        logic [15:0] slot_mask;
        logic [3:0]  slot_len;
        logic [15:0] slot_age;
        logic        pay_we;
        logic [7:0]  pay_addr;
        logic [7:0]  pay_data;
    } t_mem_req;

endpackage

// ----- sv/asps_store.sv -----
module asps_store
    import asps_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    input  logic [7:0]  i_pay_raddr,
    output logic [15:0] o_mask,
    output logic [3:0]  o_len,
    output logic [15:0] o_age,
    output logic [7:0]  o_pay
);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PD = SLOT_COUNT * PAYLOAD_MAX;
    localparam int PW = $clog2(PD);

    logic [35:0] r_slot_mem [SLOT_COUNT];
    logic [7:0]  r_pay_mem [PD];
    logic [35:0] r_slot_q;

    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) begin
            r_slot_mem[i_req.slot_addr[SW-1:0]] <=
                {i_req.slot_mask, i_req.slot_len, i_req.slot_age};
        end
        r_slot_q <= r_slot_mem[i_req.slot_addr[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pay_we) begin
            r_pay_mem[i_req.pay_addr[PW-1:0]] <= i_req.pay_data;
        end
        o_pay <= r_pay_mem[i_pay_raddr[PW-1:0]];
    end

    assign o_mask = r_slot_q[35:20];
    assign o_len  = r_slot_q[19:16];
    assign o_age  = r_slot_q[15:0];
endmodule

// ----- sv/aged_slot_packet_scheduler.sv -----
// A payload write leaves busy low; a settings write holds busy while the slot entry
// is read and written back. A transmit holds busy through an aging pass over every
// slot, then per picked slot a full scan, a pick and, if the packet has room, the
// length byte and its payload bytes, then a final scan and a done state; the last
// word leaves the cycle after done. Reset runs a clearing pass over the payload and
// slot memories with busy high; results cannot stall.
module aged_slot_packet_scheduler
    import asps_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int WINDOW_COUNT = WINDOW_COUNT_DEF,
    parameter int PAYLOAD_MAX  = PAYLOAD_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_strobe,
    output t_out_word o_out
);
    localparam int PD = SLOT_COUNT * PAYLOAD_MAX;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_AGE_R = 10'b0000000100,
        S_AGE_W = 10'b0000001000,
        S_SCAN_R = 10'b0000010000,
        S_SCAN_C = 10'b0000100000,
        S_PICK  = 10'b0001000000,
        S_EMIT_R = 10'b0010000000,
        S_EMIT_O = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_cnt, n_cnt;
    logic [4:0]  r_idx, n_idx;
    logic [3:0]  r_win, n_win;
    logic [SLOT_COUNT-1:0] r_taken, n_taken;
    logic [4:0]  r_best, n_best;
    logic        r_have, n_have;
    logic [15:0] r_best_age, n_best_age;
    logic [5:0]  r_used, n_used;
    logic [3:0]  r_len, n_len;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_mask, n_mask;
    logic        r_sent, n_sent;
    t_mem_req    req;
    logic [7:0]  pay_raddr;
    logic [15:0] m_mask, m_age;
    logic [3:0]  m_len;
    logic [7:0]  m_pay;
    logic        n_strobe;
    t_out_word   n_out;
    logic        accept;

    asps_store #(.SLOT_COUNT(SLOT_COUNT), .PAYLOAD_MAX(PAYLOAD_MAX)) u_store (
        .i_clk(i_clk), .i_req(req), .i_pay_raddr(pay_raddr),
        .o_mask(m_mask), .o_len(m_len), .o_age(m_age), .o_pay(m_pay)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_idx = r_idx; n_win = r_win;
        n_taken = r_taken; n_best = r_best; n_have = r_have;
        n_best_age = r_best_age; n_used = r_used; n_len = r_len; n_pos = r_pos;
        n_mask = r_mask; n_sent = r_sent;
        n_strobe = 1'b0;
        n_out = '0;
        req = '0;
        req.slot_addr = r_idx[3:0];
        pay_raddr = 8'((r_best[3:0] * PAYLOAD_MAX) + r_pos);
        case (r_state)
            S_CLEAR: begin
                req.pay_we = 1'b1;
                req.pay_addr = r_cnt;
                req.slot_we = (r_cnt < 8'(SLOT_COUNT));
                req.slot_addr = r_cnt[3:0];
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'(PD - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in.command)
                        CMD_SETTINGS: begin
                            // Settings write replaces mask/length; age must be kept.
                            n_idx = {1'b0, i_in.slot_number};
                            n_mask = i_in.window_mask;
                            n_len = (i_in.payload_length > 4'(PAYLOAD_MAX))
                                ? 4'(PAYLOAD_MAX) : i_in.payload_length;
                            if (5'(i_in.slot_number) < 5'(SLOT_COUNT))
                                n_state = S_AGE_R;
                            n_sent = 1'b1;
                        end
                        CMD_PAYLOAD: begin
                            req.pay_we = (5'(i_in.slot_number) < 5'(SLOT_COUNT))
                                && (i_in.byte_offset < 4'(PAYLOAD_MAX));
                            req.pay_addr = 8'(i_in.slot_number * PAYLOAD_MAX)
                                + 8'(i_in.byte_offset);
                            req.pay_data = i_in.byte_value;
                        end
                        CMD_TRANSMIT: begin
                            n_idx = '0; n_sent = 1'b0; n_state = S_AGE_R;
                            n_used = '0; n_taken = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_AGE_R: begin
                req.slot_addr = r_idx[3:0];
                n_state = S_AGE_W;
            end
            S_AGE_W: begin
                req.slot_we = 1'b1;
                req.slot_addr = r_idx[3:0];
                if (r_sent) begin
                    req.slot_mask = r_mask; req.slot_len = r_len;
                    req.slot_age = m_age;
                    n_sent = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    req.slot_mask = m_mask; req.slot_len = m_len;
                    req.slot_age = (m_age == AGE_MAX) ? m_age : m_age + 16'd1;
                    n_taken[r_idx[3:0]] = !m_mask[r_win];
                    if (r_idx == 5'(SLOT_COUNT - 1)) begin
                        n_idx = '0; n_have = 1'b0; n_state = S_SCAN_R;
                    end else begin
                        n_idx = r_idx + 5'd1; n_state = S_AGE_R;
                    end
                end
            end
            S_SCAN_R: begin
                req.slot_addr = r_idx[3:0];
                n_state = S_SCAN_C;
            end
            S_SCAN_C: begin
                if (!r_taken[r_idx[3:0]] && (!r_have || m_age > r_best_age)) begin
                    n_have = 1'b1; n_best = r_idx; n_best_age = m_age;
                end
                if (r_idx == 5'(SLOT_COUNT - 1)) begin
                    n_idx = n_best;
                    n_state = n_have ? S_PICK : S_DONE;
                end else begin
                    n_idx = r_idx + 5'd1; n_state = S_SCAN_R;
                end
            end
            S_PICK: begin
                // Slot memory output still holds the last scanned entry; reread.
                req.slot_addr = r_best[3:0];
                n_taken[r_best[3:0]] = 1'b1;
                n_state = S_EMIT_R;
                n_pos = '1;
            end
            S_EMIT_R: begin
                req.slot_addr = r_best[3:0];
                if (r_pos == '1) begin
                    n_len = m_len; n_mask = m_mask;
                    if (6'(m_len) + 6'd1 < 6'(PACKET_BYTES) - r_used) begin
                        n_state = S_EMIT_R;
                        n_strobe = 1'b1;
                        n_out.packet_byte = {r_best[3:0], m_len};
                        n_used = r_used + 6'd1;
                        n_pos = '0;
                        n_sent = 1'b1;
                    end else begin
                        n_idx = '0; n_have = 1'b0; n_state = S_SCAN_R;
                    end
                end else begin
                    // The payload address of r_pos is registered this cycle.
                    n_state = S_EMIT_O;
                end
            end
            S_EMIT_O: begin
                req.slot_addr = r_best[3:0];
                if (r_pos < 5'(r_len)) begin
                    n_strobe = 1'b1;
                    n_out.packet_byte = m_pay;
                    n_used = r_used + 6'd1;
                end
                if (r_pos + 5'd1 >= 5'(r_len)) begin
                    // Slot done: clear its age.
                    req.slot_we = 1'b1;
                    req.slot_mask = r_mask; req.slot_len = r_len; req.slot_age = '0;
                    n_idx = '0; n_have = 1'b0; n_state = S_SCAN_R;
                end else begin
                    n_pos = r_pos + 5'd1;
                    n_state = S_EMIT_R;
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_out.last_byte = 1'b1;
                n_out.empty_packet = !r_sent;
                n_win = (r_win == 4'(WINDOW_COUNT - 1)) ? '0 : r_win + 4'd1;
                n_state = S_IDLE;
                n_sent = 1'b0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Packet bytes are held in a register so the final byte can carry last_byte.
    logic       r_hold_v;
    t_out_word  r_hold;
    logic       r_strobe;
    t_out_word  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_cnt <= '0; r_idx <= '0; r_win <= '0;
            r_taken <= '0; r_have <= 1'b0; r_used <= '0; r_sent <= 1'b0;
            r_hold_v <= 1'b0; r_strobe <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_idx <= n_idx; r_win <= n_win;
            r_taken <= n_taken; r_have <= n_have; r_used <= n_used;
            r_sent <= n_sent;
            r_strobe <= n_strobe && (r_hold_v || (r_state == S_DONE));
            if (n_strobe) begin
                if (r_state == S_DONE) begin
                    if (r_hold_v) begin
                        r_out <= '{packet_byte: r_hold.packet_byte, last_byte: 1'b1,
                                   empty_packet: r_hold.empty_packet};
                    end else begin
                        r_out <= n_out;
                    end
                    r_hold_v <= 1'b0;
                end else begin
                    if (r_hold_v) begin
                        r_out <= r_hold;
                    end
                    r_hold <= n_out;
                    r_hold_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best; r_best_age <= n_best_age; r_len <= n_len;
        r_pos <= n_pos; r_mask <= n_mask;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

`ifndef ASSERT_OFF
    a_no_start_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy) else $error("idle during clear");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used < 6'(PACKET_BYTES)) else $error("packet overflow");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.empty_packet) |-> o_out.last_byte)
        else $error("empty marker without last");
`endif
endmodule
